[hw/rtl/kvc_pkg.sv]
// shared types, constants and op codes of the keyed value cache
// no dependencies; every other file of the block refers to this package
package kvc_pkg;

  // table geometry
  localparam int STORE_DEPTH      = 1024;
  localparam int NODE_SLOTS_DEF   = 64;
  localparam int METRIC_SLOTS_DEF = 16;
  localparam int LIST_LIMIT_DEF   = 64;

  // field widths
  localparam int OP_W     = 3;
  localparam int NODE_W   = 16;
  localparam int METRIC_W = 8;
  localparam int VAL_W    = 32;
  localparam int LIM_W    = 7;
  localparam int CNT_W    = 11;
  localparam int STAT_W   = 32;

  // op codes
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ    = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_LIST    = 3'd3;
  localparam logic [OP_W-1:0] OP_STATS   = 3'd4;
  // unassigned op codes, answered with a failed word
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  // table capacity, held to the store depth
  function automatic int capacity(input int nodes, input int metrics);
    int prod;
    prod = nodes * metrics;
    return (prod > STORE_DEPTH) ? STORE_DEPTH : prod;
  endfunction

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [NODE_W-1:0]   node_id;
    logic [METRIC_W-1:0] metric_key;
    logic [VAL_W-1:0]    value;
    logic [LIM_W-1:0]    max_count;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [VAL_W-1:0]    entry_value;
    logic                entry_dirty;
    logic [NODE_W-1:0]   entry_node;
    logic [METRIC_W-1:0] entry_metric;
    logic                last;
    logic [CNT_W-1:0]    entry_count;
    logic [STAT_W-1:0]   update_count;
    logic [STAT_W-1:0]   suppressed_count;
    logic [STAT_W-1:0]   hit_count;
  } res_t;

  // one table entry as stored in the entry ram
  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [METRIC_W-1:0] metric;
    logic [VAL_W-1:0]    value;
    logic                dirty;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic load;   // latch a new request
    logic imm;    // request answered without a scan
    logic scan;   // issue table reads
    logic hit;    // act on the matching entry
    logic miss;   // act on the end of the scan
    logic flush;  // present the held list entry as final
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic imm_req;
    logic found;
    logic exhausted;
    logic is_list;
    logic pend_v;
    logic lim_hit;
  } sts_t;

endpackage

[hw/rtl/kvc_ifs.sv]
// request and result channel interfaces of the keyed value cache
// depends on kvc_pkg for field widths
interface kvc_in_if;
  logic                         valid;
  logic                         ready;
  logic [kvc_pkg::OP_W-1:0]     op;
  logic [kvc_pkg::NODE_W-1:0]   node_id;
  logic [kvc_pkg::METRIC_W-1:0] metric_key;
  logic [kvc_pkg::VAL_W-1:0]    value;
  logic [kvc_pkg::LIM_W-1:0]    max_count;

  modport source(output valid, op, node_id, metric_key, value, max_count, input ready);
  modport sink(input valid, op, node_id, metric_key, value, max_count, output ready);
endinterface

interface kvc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [kvc_pkg::VAL_W-1:0]    entry_value;
  logic                         entry_dirty;
  logic [kvc_pkg::NODE_W-1:0]   entry_node;
  logic [kvc_pkg::METRIC_W-1:0] entry_metric;
  logic                         last;
  logic [kvc_pkg::CNT_W-1:0]    entry_count;
  logic [kvc_pkg::STAT_W-1:0]   update_count;
  logic [kvc_pkg::STAT_W-1:0]   suppressed_count;
  logic [kvc_pkg::STAT_W-1:0]   hit_count;

  modport source(output valid, ok, entry_value, entry_dirty, entry_node, entry_metric, last,
                 entry_count, update_count, suppressed_count, hit_count, input ready);
  modport sink(input valid, ok, entry_value, entry_dirty, entry_node, entry_metric, last,
               entry_count, update_count, suppressed_count, hit_count, output ready);
endinterface

[hw/rtl/kvc_ram.sv]
// generic single write port ram with one registered read port
// depends on kvc_pkg for default sizes
module kvc_ram #(
  parameter int WIDTH = kvc_pkg::ENTRY_W,
  parameter int DEPTH = kvc_pkg::STORE_DEPTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/kvc_datapath.sv]
// datapath: request latch, scan address pipeline, entry ram, counters, result register
// depends on kvc_pkg and kvc_ram
module kvc_datapath #(
  parameter int CAPACITY   = kvc_pkg::capacity(kvc_pkg::NODE_SLOTS_DEF,
                                               kvc_pkg::METRIC_SLOTS_DEF),
  parameter int LIST_LIMIT = kvc_pkg::LIST_LIMIT_DEF,
  localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  kvc_pkg::req_t req_in,
  input  kvc_pkg::cmd_t cmd,
  output kvc_pkg::sts_t sts,
  output kvc_pkg::res_t res
);

  localparam logic [kvc_pkg::CNT_W-1:0] CAP_C = kvc_pkg::CNT_W'(CAPACITY);
  localparam logic [kvc_pkg::LIM_W-1:0] LIM_C = kvc_pkg::LIM_W'(LIST_LIMIT);

  kvc_pkg::req_t                 req_r;
  logic [kvc_pkg::LIM_W-1:0]     lim_r;
  logic [kvc_pkg::LIM_W-1:0]     cnt_r;
  logic [kvc_pkg::CNT_W-1:0]     rd_idx_r;
  logic [kvc_pkg::CNT_W-1:0]     chk_idx_r;
  logic                          chk_v_r;
  logic [kvc_pkg::CNT_W-1:0]     used_r;
  logic [kvc_pkg::STAT_W-1:0]    upd_r;
  logic [kvc_pkg::STAT_W-1:0]    sup_r;
  logic [kvc_pkg::STAT_W-1:0]    hit_r;
  logic                          pend_v_r;
  kvc_pkg::entry_t               pend_r;
  kvc_pkg::res_t                 res_r;
  kvc_pkg::res_t                 res_nxt;

  logic [kvc_pkg::ENTRY_W-1:0]   rdata;
  kvc_pkg::entry_t               ent;
  logic                          is_list;
  logic                          key_eq;
  logic                          issue;
  logic                          restart;
  logic                          has_room;
  logic                          we;
  logic [AW-1:0]                 waddr;
  kvc_pkg::entry_t               wdata;

  // result word for one listed entry
  function automatic kvc_pkg::res_t list_res(input kvc_pkg::entry_t e, input logic lst);
    kvc_pkg::res_t r;
    r              = '0;
    r.ok           = 1'b1;
    r.entry_value  = e.value;
    r.entry_dirty  = 1'b1;
    r.entry_node   = e.node;
    r.entry_metric = e.metric;
    r.last         = lst;
    return r;
  endfunction

  // entry storage
  kvc_ram #(
    .WIDTH(kvc_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(rdata)
  );

  // scan status
  assign ent      = kvc_pkg::entry_t'(rdata);
  assign is_list  = (req_r.op == kvc_pkg::OP_LIST);
  assign key_eq   = (ent.node == req_r.node_id) && (ent.metric == req_r.metric_key);
  assign issue    = cmd.scan && (rd_idx_r < used_r);
  assign restart  = cmd.hit && is_list && pend_v_r;
  assign has_room = (used_r < CAP_C);

  assign sts.imm_req   = (req_in.op == kvc_pkg::OP_STATS) || (req_in.op > kvc_pkg::OP_STATS) ||
                         ((req_in.op == kvc_pkg::OP_LIST) && (req_in.max_count == '0));
  assign sts.found     = chk_v_r && (is_list ? ent.dirty : key_eq);
  assign sts.exhausted = !chk_v_r && (rd_idx_r >= used_r);
  assign sts.is_list   = is_list;
  assign sts.pend_v    = pend_v_r;
  assign sts.lim_hit   = (kvc_pkg::LIM_W'(cnt_r + 7'd1) == lim_r);

  // ram write: update on hit, clear dirty on hit, append on miss
  always_comb begin
    we    = 1'b0;
    waddr = chk_idx_r[AW-1:0];
    wdata = ent;
    if (cmd.hit && (req_r.op == kvc_pkg::OP_WRITE) && (ent.value != req_r.value)) begin
      we          = 1'b1;
      wdata.value = req_r.value;
      wdata.dirty = 1'b1;
    end else if (cmd.hit && (req_r.op == kvc_pkg::OP_CLEAR)) begin
      we          = 1'b1;
      wdata.dirty = 1'b0;
    end else if (cmd.miss && (req_r.op == kvc_pkg::OP_WRITE) && has_room) begin
      we           = 1'b1;
      waddr        = used_r[AW-1:0];
      wdata.node   = req_r.node_id;
      wdata.metric = req_r.metric_key;
      wdata.value  = req_r.value;
      wdata.dirty  = 1'b1;
    end
  end

  // next result word
  always_comb begin
    res_nxt = res_r;
    if (cmd.load && cmd.imm) begin
      res_nxt      = '0;
      res_nxt.last = 1'b1;
      if (req_in.op == kvc_pkg::OP_STATS) begin
        res_nxt.ok               = 1'b1;
        res_nxt.entry_count      = used_r;
        res_nxt.update_count     = upd_r;
        res_nxt.suppressed_count = sup_r;
        res_nxt.hit_count        = hit_r;
      end
    end else if (cmd.hit) begin
      res_nxt      = '0;
      res_nxt.ok   = 1'b1;
      res_nxt.last = 1'b1;
      case (req_r.op)
        kvc_pkg::OP_READ: begin
          res_nxt.entry_value = ent.value;
          res_nxt.entry_dirty = ent.dirty;
        end
        kvc_pkg::OP_LIST: begin
          if (pend_v_r) begin
            res_nxt = list_res(pend_r, 1'b0);
          end else begin
            res_nxt = list_res(ent, 1'b1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.miss) begin
      res_nxt      = '0;
      res_nxt.last = 1'b1;
      if (is_list && pend_v_r) begin
        res_nxt = list_res(pend_r, 1'b1);
      end else if ((req_r.op == kvc_pkg::OP_WRITE) && has_room) begin
        res_nxt.ok = 1'b1;
      end
    end else if (cmd.flush) begin
      res_nxt = list_res(pend_r, 1'b1);
    end
  end

  // control registers: scan pointer, fill count, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      chk_v_r  <= 1'b0;
      used_r   <= '0;
      upd_r    <= '0;
      sup_r    <= '0;
      hit_r    <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx_r <= '0;
        chk_v_r  <= 1'b0;
        cnt_r    <= '0;
        pend_v_r <= 1'b0;
        if (req_in.op == kvc_pkg::OP_WRITE) begin
          upd_r <= upd_r + 32'd1;
        end
      end else if (restart) begin
        rd_idx_r <= chk_idx_r + 11'd1;
        chk_v_r  <= 1'b0;
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + 11'd1;
        chk_v_r  <= 1'b1;
      end else begin
        chk_v_r <= 1'b0;
      end
      if (cmd.hit) begin
        if (req_r.op == kvc_pkg::OP_WRITE) begin
          if (ent.value == req_r.value) begin
            sup_r <= sup_r + 32'd1;
          end else begin
            hit_r <= hit_r + 32'd1;
          end
        end
        if (is_list) begin
          pend_v_r <= 1'b1;
          cnt_r    <= cnt_r + 7'd1;
        end
      end
      if (cmd.miss && (req_r.op == kvc_pkg::OP_WRITE) && has_room) begin
        used_r <= used_r + 11'd1;
        hit_r  <= hit_r + 32'd1;
      end
    end
  end

  // payload registers: request, scan index, held list entry, result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_in;
      lim_r <= (req_in.max_count > LIM_C) ? LIM_C : req_in.max_count;
    end
    if (issue && !restart) begin
      chk_idx_r <= rd_idx_r;
    end
    if (cmd.hit && is_list) begin
      pend_r <= ent;
    end
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[hw/rtl/kvc_ctrl.sv]
// controller: sequences load, table scan and result handshake
// depends on kvc_pkg
module kvc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  kvc_pkg::sts_t sts,
  output kvc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT,
    ST_OUT_CONT,
    ST_OUT_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.imm   = sts.imm_req;
          state_nxt = sts.imm_req ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          cmd.hit = 1'b1;
          if (!sts.is_list) begin
            state_nxt = ST_OUT;
          end else if (!sts.pend_v) begin
            state_nxt = sts.lim_hit ? ST_OUT : ST_SCAN;
          end else begin
            state_nxt = sts.lim_hit ? ST_OUT_FLUSH : ST_OUT_CONT;
          end
        end else if (sts.exhausted) begin
          cmd.miss  = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT_CONT: begin
        if (out_ready) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_OUT_FLUSH: begin
        if (out_ready) begin
          cmd.flush = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == ST_OUT) || (state_nxt == ST_OUT_CONT) ||
                     (state_nxt == ST_OUT_FLUSH);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/keyed_value_cache_with_dirty_tracking.sv]
// keyed value cache with dirty tracking, one request word at a time
// write/read/clear/list scan one entry per cycle through the registered ram read port,
// pausing while a listed word waits for the receiver; the scan address and the ram read
// are registered before a match is checked; immediate replies are valid in the cycle
// after the request is taken; the next request is taken in the cycle after the final word
// synchronous reset (rst_n low) clears fill count and counters; entry ram is not cleared
module keyed_value_cache_with_dirty_tracking #(
  parameter int NODE_SLOTS   = kvc_pkg::NODE_SLOTS_DEF,
  parameter int METRIC_SLOTS = kvc_pkg::METRIC_SLOTS_DEF,
  parameter int LIST_LIMIT   = kvc_pkg::LIST_LIMIT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  kvc_in_if.sink     in_ch,
  kvc_out_if.source  out_ch
);

  localparam int CAPACITY = kvc_pkg::capacity(NODE_SLOTS, METRIC_SLOTS);

  kvc_pkg::req_t req;
  kvc_pkg::res_t res;
  kvc_pkg::cmd_t cmd;
  kvc_pkg::sts_t sts;

  // request word
  assign req.op         = in_ch.op;
  assign req.node_id    = in_ch.node_id;
  assign req.metric_key = in_ch.metric_key;
  assign req.value      = in_ch.value;
  assign req.max_count  = in_ch.max_count;

  kvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kvc_datapath #(
    .CAPACITY  (CAPACITY),
    .LIST_LIMIT(LIST_LIMIT)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .req_in(req),
    .cmd   (cmd),
    .sts   (sts),
    .res   (res)
  );

  // result word
  assign out_ch.ok               = res.ok;
  assign out_ch.entry_value      = res.entry_value;
  assign out_ch.entry_dirty      = res.entry_dirty;
  assign out_ch.entry_node       = res.entry_node;
  assign out_ch.entry_metric     = res.entry_metric;
  assign out_ch.last             = res.last;
  assign out_ch.entry_count      = res.entry_count;
  assign out_ch.update_count     = res.update_count;
  assign out_ch.suppressed_count = res.suppressed_count;
  assign out_ch.hit_count        = res.hit_count;

`ifndef ASSERT_OFF
  // never take a request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready))
    else $error("request taken while result pending");

  // fill count never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.entry_count <= kvc_pkg::CNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

  // after the final word the block is free for the next request
  a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("not ready after final word");

  // a non-final word is always followed by more of the same request
  a_more_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> !in_ch.ready)
    else $error("request ended without a final word");
`endif

endmodule

[bench/keyed_value_cache_with_dirty_tracking_tb.sv]
// testbench for the keyed value cache with dirty tracking
// depends on kvc_pkg, kvc_ifs and the cache top level; predicts every result word
`timescale 1ns / 1ps

module keyed_value_cache_with_dirty_tracking_tb;

  localparam int CAP = kvc_pkg::capacity(kvc_pkg::NODE_SLOTS_DEF, kvc_pkg::METRIC_SLOTS_DEF);
  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic clk;
  logic rst_n;

  kvc_in_if  in_ch();
  kvc_out_if out_ch();

  keyed_value_cache_with_dirty_tracking uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor copy of the table
  logic [kvc_pkg::NODE_W-1:0]   tbl_node[CAP];
  logic [kvc_pkg::METRIC_W-1:0] tbl_metric[CAP];
  logic [kvc_pkg::VAL_W-1:0]    tbl_value[CAP];
  logic                         tbl_dirty[CAP];
  int unsigned                  tbl_used;
  logic [kvc_pkg::STAT_W-1:0]   upd_tot, sup_tot, hit_tot;

  kvc_pkg::res_t pending_results[$];
  int     mismatch_cnt;
  int     result_cnt;
  int     sent_cnt;
  longint cycle_cnt = 0;
  int     stall_mode = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter with timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int find_key(logic [kvc_pkg::NODE_W-1:0] n,
                                  logic [kvc_pkg::METRIC_W-1:0] m);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_node[i] == n && tbl_metric[i] == m) return i;
    return -1;
  endfunction

  // compute the words one request produces
  task automatic predict_request(kvc_pkg::req_t rq);
    kvc_pkg::res_t r;
    int idx;
    int lim;
    int n;
    r = '0;
    r.last = 1'b1;
    case (rq.op)
      kvc_pkg::OP_WRITE: begin
        upd_tot++;
        idx = find_key(rq.node_id, rq.metric_key);
        if (idx >= 0) begin
          if (tbl_value[idx] == rq.value) sup_tot++;
          else begin
            tbl_value[idx] = rq.value;
            tbl_dirty[idx] = 1'b1;
            hit_tot++;
          end
          r.ok = 1'b1;
        end else if (tbl_used < CAP) begin
          tbl_node[tbl_used] = rq.node_id;
          tbl_metric[tbl_used] = rq.metric_key;
          tbl_value[tbl_used] = rq.value;
          tbl_dirty[tbl_used] = 1'b1;
          tbl_used++;
          hit_tot++;
          r.ok = 1'b1;
        end
        pending_results.push_back(r);
      end
      kvc_pkg::OP_READ: begin
        idx = find_key(rq.node_id, rq.metric_key);
        if (idx >= 0) begin
          r.ok = 1'b1;
          r.entry_value = tbl_value[idx];
          r.entry_dirty = tbl_dirty[idx];
        end
        pending_results.push_back(r);
      end
      kvc_pkg::OP_CLEAR: begin
        idx = find_key(rq.node_id, rq.metric_key);
        if (idx >= 0) begin
          tbl_dirty[idx] = 1'b0;
          r.ok = 1'b1;
        end
        pending_results.push_back(r);
      end
      kvc_pkg::OP_LIST: begin
        lim = (rq.max_count < kvc_pkg::LIST_LIMIT_DEF) ? rq.max_count
                                                       : kvc_pkg::LIST_LIMIT_DEF;
        n = 0;
        for (int i = 0; i < tbl_used && n < lim; i++) begin
          if (tbl_dirty[i]) begin
            r = '0;
            r.ok = 1'b1;
            r.entry_value = tbl_value[i];
            r.entry_dirty = 1'b1;
            r.entry_node = tbl_node[i];
            r.entry_metric = tbl_metric[i];
            pending_results.push_back(r);
            n++;
          end
        end
        if (n == 0) begin
          r = '0;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      kvc_pkg::OP_STATS: begin
        r.ok = 1'b1;
        r.entry_count = tbl_used[kvc_pkg::CNT_W-1:0];
        r.update_count = upd_tot;
        r.suppressed_count = sup_tot;
        r.hit_count = hit_tot;
        pending_results.push_back(r);
      end
      default: pending_results.push_back(r);
    endcase
  endtask

  // send one request word, idle for the given gap first
  task automatic send_word(kvc_pkg::req_t rq, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= rq.op;
    in_ch.node_id    <= rq.node_id;
    in_ch.metric_key <= rq.metric_key;
    in_ch.value      <= rq.value;
    in_ch.max_count  <= rq.max_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_request(rq);
    sent_cnt++;
  endtask

  function automatic kvc_pkg::req_t mk(logic [kvc_pkg::OP_W-1:0] op,
                                       logic [kvc_pkg::NODE_W-1:0] n,
                                       logic [kvc_pkg::METRIC_W-1:0] m,
                                       logic [kvc_pkg::VAL_W-1:0] v,
                                       logic [kvc_pkg::LIM_W-1:0] c);
    kvc_pkg::req_t rq;
    rq.op = op; rq.node_id = n; rq.metric_key = m; rq.value = v; rq.max_count = c;
    return rq;
  endfunction

  // receiver stall pattern, changes mode now and then
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= cycle_cnt[2];
      endcase
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    end
  end

  // result checker
  always @(posedge clk) begin
    kvc_pkg::res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ok = out_ch.ok;
      got.entry_value = out_ch.entry_value;
      got.entry_dirty = out_ch.entry_dirty;
      got.entry_node = out_ch.entry_node;
      got.entry_metric = out_ch.entry_metric;
      got.last = out_ch.last;
      got.entry_count = out_ch.entry_count;
      got.update_count = out_ch.update_count;
      got.suppressed_count = out_ch.suppressed_count;
      got.hit_count = out_ch.hit_count;
      result_cnt++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch word %0d: exp ok=%b v=%h d=%b n=%h m=%h l=%b c=%0d",
                     result_cnt, want.ok, want.entry_value, want.entry_dirty,
                     want.entry_node, want.entry_metric, want.last, want.entry_count);
            $display("  exp u=%0d s=%0d h=%0d", want.update_count,
                     want.suppressed_count, want.hit_count);
            $display("  got ok=%b v=%h d=%b n=%h m=%h l=%b c=%0d u=%0d s=%0d h=%0d",
                     got.ok, got.entry_value, got.entry_dirty, got.entry_node,
                     got.entry_metric, got.last, got.entry_count, got.update_count,
                     got.suppressed_count, got.hit_count);
          end
        end
      end
    end
  end

  // directed corner cases
  task automatic test_directed();
    send_word(mk(kvc_pkg::OP_LIST, 16'd0, 8'd0, 32'd0, 7'd10), 0);   // empty table list
    send_word(mk(kvc_pkg::OP_READ, 16'hFFFF, 8'hFF, 32'd0, 7'd0), 0); // read miss
    send_word(mk(kvc_pkg::OP_CLEAR, 16'd1, 8'd1, 32'd0, 7'd0), 1);    // clear miss
    send_word(mk(kvc_pkg::OP_WRITE, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 7'h7F), 0);
    send_word(mk(kvc_pkg::OP_WRITE, 16'd0, 8'd0, 32'h0000_0000, 7'd0), 2); // +0
    send_word(mk(kvc_pkg::OP_WRITE, 16'd0, 8'd0, 32'h8000_0000, 7'd0), 0); // -0 differs
    send_word(mk(kvc_pkg::OP_WRITE, 16'd0, 8'd0, 32'h8000_0000, 7'd0), 0); // suppressed
    send_word(mk(kvc_pkg::OP_WRITE, 16'd5, 8'd3, 32'h7FC0_0001, 7'd0), 0); // nan pattern
    send_word(mk(kvc_pkg::OP_WRITE, 16'd5, 8'd3, 32'h7FC0_0001, 7'd0), 0); // nan equals itself
    send_word(mk(kvc_pkg::OP_READ, 16'd0, 8'd0, 32'd0, 7'd0), 0);
    send_word(mk(kvc_pkg::OP_CLEAR, 16'd0, 8'd0, 32'd0, 7'd0), 0);
    send_word(mk(kvc_pkg::OP_READ, 16'd0, 8'd0, 32'd0, 7'd0), 3);
    send_word(mk(kvc_pkg::OP_LIST, 16'd0, 8'd0, 32'd0, 7'd0), 0);     // zero count
    send_word(mk(kvc_pkg::OP_LIST, 16'd0, 8'd0, 32'd0, 7'd1), 0);
    send_word(mk(kvc_pkg::OP_LIST, 16'd0, 8'd0, 32'd0, 7'h7F), 0);    // above the list limit
    send_word(mk(kvc_pkg::OP_STATS, 16'd0, 8'd0, 32'd0, 7'd0), 0);
    send_word(mk(kvc_pkg::OP_RSVD_LO, 16'd0, 8'd0, 32'd0, 7'd0), 0);
    send_word(mk(kvc_pkg::OP_RSVD_LO + 3'd1, 16'hAAAA, 8'h55, 32'h1234, 7'd3), 0);
    send_word(mk(kvc_pkg::OP_RSVD_HI, 16'd0, 8'd0, 32'd0, 7'd0), 0);
    send_word(mk(kvc_pkg::OP_CLEAR, 16'hFFFF, 8'hFF, 32'd0, 7'd0), 0);
    send_word(mk(kvc_pkg::OP_LIST, 16'd0, 8'd0, 32'd0, 7'd64), 0);    // one dirty left
    send_word(mk(kvc_pkg::OP_STATS, 16'd0, 8'd0, 32'd0, 7'd0), 0);
  endtask

  // random traffic over a small key space, bursts and gaps
  task automatic test_random(int count);
    kvc_pkg::req_t rq;
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
      end else gap = 0;
      burst--;
      rq.op = ($urandom_range(0, 19) == 0)
              ? 3'($urandom_range(kvc_pkg::OP_RSVD_LO, kvc_pkg::OP_RSVD_HI))
              : 3'($urandom_range(kvc_pkg::OP_WRITE, kvc_pkg::OP_STATS));
      if ($urandom_range(0, 1) == 0) rq.op = kvc_pkg::OP_WRITE;
      if ($urandom_range(0, 9) == 0) begin
        rq.node_id = 16'($urandom);
        rq.metric_key = 8'($urandom);
      end else begin
        rq.node_id = 16'($urandom_range(0, 7)) ^ {16{$urandom_range(0, 7) == 0}};
        rq.metric_key = 8'($urandom_range(0, 3));
      end
      rq.value = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : 32'($urandom);
      rq.max_count = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 8));
      send_word(rq, gap);
    end
  endtask

  initial begin
    int waited;
    mismatch_cnt = 0;
    result_cnt = 0;
    sent_cnt = 0;
    tbl_used = 0;
    upd_tot = '0; sup_tot = '0; hit_tot = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = '0; in_ch.node_id = '0; in_ch.metric_key = '0;
    in_ch.value = '0; in_ch.max_count = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(338);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2200) @(posedge clk);
    $display("sent %0d request words, checked %0d result words, table filled to %0d",
             sent_cnt, result_cnt, tbl_used);
    $display("mismatches %0d, results still pending %0d",
             mismatch_cnt, pending_results.size());
    if (mismatch_cnt == 0 && pending_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
